>>> sv/kmc_pkg.sv
// Shared constants, codes and types of the k-means clustering engine.
`default_nettype none
package kmc_pkg;
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_DIM      = 16;
  localparam int MAX_CLUSTERS = 16;
  localparam int VALUE_WIDTH  = 16;
  localparam int MAX_ITER     = 255;

  localparam int PT_W   = $clog2(MAX_POINTS);
  localparam int EL_W   = $clog2(MAX_DIM);
  localparam int CL_W   = $clog2(MAX_CLUSTERS);
  localparam int NP_W   = PT_W + 1;
  localparam int ND_W   = EL_W + 1;
  localparam int NK_W   = CL_W + 1;
  localparam int IT_W   = 8;
  localparam int THR_W  = 32;
  localparam int PA_W   = PT_W + EL_W;
  localparam int CA_W   = CL_W + EL_W;
  localparam int SUM_W  = VALUE_WIDTH + PT_W + 1;
  localparam int DIFF_W = VALUE_WIDTH + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ACC_W  = SQ_W + EL_W;
  localparam int DC_W   = $clog2(SUM_W + 1);
  localparam int CLR_W  = (PT_W > CA_W) ? PT_W : CA_W;
  localparam int MODE_W = 3;
  localparam int IDX_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_PT  = 3'd0,
    MODE_LOAD_CEN = 3'd1,
    MODE_RUN      = 3'd2,
    MODE_Q_ASSIGN = 3'd3,
    MODE_Q_CEN    = 3'd4
  } mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_NUM_POINTS   = 3'd0,
    REG_VECTOR_DIM   = 3'd1,
    REG_NUM_CLUSTERS = 3'd2,
    REG_ITER_LIMIT   = 3'd3,
    REG_SHIFT_THR    = 3'd4
  } cfg_reg_e;
endpackage
`default_nettype wire

>>> sv/kmc_ifs.sv
// Handshake channels of the k-means engine: input items, result items, register writes.
`default_nettype none
interface kmc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [kmc_pkg::MODE_W-1:0]            mode;
  logic [kmc_pkg::PT_W-1:0]              point_index;
  logic [kmc_pkg::CL_W-1:0]              cluster_index;
  logic [kmc_pkg::EL_W-1:0]              element_index;
  logic signed [kmc_pkg::VALUE_WIDTH-1:0] value;
  modport source (output valid, mode, point_index, cluster_index, element_index, value,
                  input ready);
  modport sink (input valid, mode, point_index, cluster_index, element_index, value,
                output ready);
endinterface

interface kmc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [kmc_pkg::CL_W-1:0]              assigned_cluster;
  logic signed [kmc_pkg::VALUE_WIDTH-1:0] centroid_value;
  logic [kmc_pkg::IT_W-1:0]              iterations_used;
  logic                                  converged;
  modport source (output valid, assigned_cluster, centroid_value, iterations_used, converged,
                  input ready);
  modport sink (input valid, assigned_cluster, centroid_value, iterations_used, converged,
                output ready);
endinterface

interface kmc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kmc_pkg::IDX_W-1:0]   index;
  logic [kmc_pkg::THR_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/kmc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module kmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/kmeans_lloyd_clustering_top.sv
// Top level of the Lloyd k-means engine: sequencer, shared squarer and divider, stores.
// Load items are accepted while idle and leave the block idle; a query reads its store on
// acceptance and registers its result from S_QRES once the output register is free. The pace
// of a run is set by the single shared subtract-square unit and the 27-step serial divider.
// After reset the block clears every entry of the assignment store before taking items;
// configuration writes are taken at any time. Reset restores all configuration defaults.
`default_nettype none
module kmeans_lloyd_clustering_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  kmc_in_if.sink    in_i,
  kmc_out_if.source out_o,
  kmc_cfg_if.sink   cfg_i
);
  localparam int VW = kmc_pkg::VALUE_WIDTH;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_QRES, S_ITER, S_SCLR, S_ARD, S_AACC, S_AWR, S_SRD, S_SWR,
    S_UCHK, S_URD, S_ULAT, S_UDIV, S_USH, S_ICHK, S_RES
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [kmc_pkg::NP_W-1:0]  num_points_q;
  logic [kmc_pkg::ND_W-1:0]  vector_dim_q;
  logic [kmc_pkg::NK_W-1:0]  num_clusters_q;
  logic [kmc_pkg::IT_W-1:0]  iter_limit_q;
  logic [kmc_pkg::THR_W-1:0] shift_thr_q;

  // Sequencer counters and datapath registers.
  logic [kmc_pkg::CLR_W-1:0]       clr_q;
  logic [kmc_pkg::PT_W-1:0]        pt_q;
  logic [kmc_pkg::CL_W-1:0]        cl_q;
  logic [kmc_pkg::EL_W-1:0]        el_q;
  logic [kmc_pkg::CL_W-1:0]        bc_q;
  logic [kmc_pkg::IT_W-1:0]        it_q;
  logic [kmc_pkg::ACC_W-1:0]       acc_q;
  logic [kmc_pkg::ACC_W-1:0]       best_q;
  logic [kmc_pkg::ACC_W-1:0]       maxs_q;
  logic [kmc_pkg::NP_W-1:0]        cnt_q [kmc_pkg::MAX_CLUSTERS];
  logic [kmc_pkg::SUM_W-1:0]       dq_q;
  logic [kmc_pkg::NP_W-1:0]        rem_q;
  logic [kmc_pkg::DC_W-1:0]        dcnt_q;
  logic                            neg_q;
  logic signed [VW-1:0]            old_q;
  logic                            conv_q;

  // Result register.
  logic                            out_valid_q;
  logic [kmc_pkg::CL_W-1:0]        out_ac_q;
  logic signed [VW-1:0]            out_cv_q;
  logic [kmc_pkg::IT_W-1:0]        out_it_q;
  logic                            out_conv_q;

  // RAM ports.
  logic                      pt_we, cen_we, sum_we, asg_we;
  logic [kmc_pkg::PA_W-1:0]  pt_waddr, pt_raddr;
  logic [kmc_pkg::CA_W-1:0]  cen_waddr, cen_raddr, sum_waddr, sum_raddr;
  logic [kmc_pkg::PT_W-1:0]  asg_waddr, asg_raddr;
  logic [VW-1:0]             pt_wdata, pt_rdata, cen_wdata, cen_rdata;
  logic [kmc_pkg::SUM_W-1:0] sum_wdata, sum_rdata;
  logic [kmc_pkg::CL_W-1:0]  asg_wdata, asg_rdata;

  logic in_fire, out_free;
  logic [kmc_pkg::PT_W-1:0] last_pt;
  logic [kmc_pkg::EL_W-1:0] last_el;
  logic [kmc_pkg::CL_W-1:0] last_cl;
  logic [kmc_pkg::IT_W-1:0] lim;
  logic [kmc_pkg::IT_W-1:0] it_next;

  // Shared subtract-square unit.
  logic signed [VW-1:0]             sq_a, sq_b;
  logic signed [kmc_pkg::DIFF_W-1:0] diff;
  logic [kmc_pkg::DIFF_W-1:0]        adiff;
  logic [kmc_pkg::SQ_W-1:0]          sq;
  logic [kmc_pkg::ACC_W-1:0]         acc_sum;
  logic                              take_best;

  // Divider step and centroid result.
  logic [kmc_pkg::CL_W-1:0]   cnt_idx;
  logic [kmc_pkg::NP_W-1:0]   divisor;
  logic [kmc_pkg::NP_W:0]     dtrial;
  logic                       dge;
  logic [kmc_pkg::NP_W:0]     dsub;
  logic signed [VW-1:0]       new_val;
  logic signed [kmc_pkg::SUM_W-1:0] sum_s, sum_new;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid            = out_valid_q;
  assign out_o.assigned_cluster = out_ac_q;
  assign out_o.centroid_value   = out_cv_q;
  assign out_o.iterations_used  = out_it_q;
  assign out_o.converged        = out_conv_q;

  // Register values are clamped into their legal ranges when used.
  always_comb begin
    if (num_points_q == '0) begin
      last_pt = '0;
    end else if (num_points_q > kmc_pkg::NP_W'(kmc_pkg::MAX_POINTS)) begin
      last_pt = kmc_pkg::PT_W'(kmc_pkg::MAX_POINTS - 1);
    end else begin
      last_pt = kmc_pkg::PT_W'(num_points_q - 1'b1);
    end
    if (vector_dim_q == '0) begin
      last_el = '0;
    end else if (vector_dim_q > kmc_pkg::ND_W'(kmc_pkg::MAX_DIM)) begin
      last_el = kmc_pkg::EL_W'(kmc_pkg::MAX_DIM - 1);
    end else begin
      last_el = kmc_pkg::EL_W'(vector_dim_q - 1'b1);
    end
    if (num_clusters_q == '0) begin
      last_cl = '0;
    end else if (num_clusters_q > kmc_pkg::NK_W'(kmc_pkg::MAX_CLUSTERS)) begin
      last_cl = kmc_pkg::CL_W'(kmc_pkg::MAX_CLUSTERS - 1);
    end else begin
      last_cl = kmc_pkg::CL_W'(num_clusters_q - 1'b1);
    end
    lim = (iter_limit_q == '0) ? kmc_pkg::IT_W'(1) : iter_limit_q;
  end

  assign it_next = it_q + 1'b1;

  // The squarer serves distances during assignment and shifts during update.
  assign sq_a    = (state_q == S_USH) ? new_val : $signed(pt_rdata);
  assign sq_b    = (state_q == S_USH) ? old_q : $signed(cen_rdata);
  assign diff    = kmc_pkg::DIFF_W'(sq_a) - kmc_pkg::DIFF_W'(sq_b);
  assign adiff   = diff[kmc_pkg::DIFF_W-1] ? kmc_pkg::DIFF_W'(-diff) : diff;
  assign sq      = adiff * adiff;
  assign acc_sum = acc_q + kmc_pkg::ACC_W'(sq);
  assign take_best = (cl_q == '0) || (acc_sum < best_q);

  assign cnt_idx = (state_q == S_AWR) ? bc_q : cl_q;
  assign divisor = cnt_q[cnt_idx];
  assign dtrial  = {rem_q, dq_q[kmc_pkg::SUM_W-1]};
  assign dge     = dtrial >= {1'b0, divisor};
  assign dsub    = dtrial - {1'b0, divisor};
  assign new_val = neg_q ? -$signed(dq_q[VW-1:0]) : $signed(dq_q[VW-1:0]);

  assign sum_s   = $signed(sum_rdata);
  assign sum_new = sum_s + kmc_pkg::SUM_W'($signed(pt_rdata));

  // Memory port steering.
  always_comb begin
    pt_we     = in_fire && (in_i.mode == kmc_pkg::MODE_LOAD_PT);
    pt_waddr  = {in_i.point_index, in_i.element_index};
    pt_wdata  = in_i.value;
    pt_raddr  = {pt_q, el_q};

    cen_we    = 1'b0;
    cen_waddr = {cl_q, el_q};
    cen_wdata = new_val;
    cen_raddr = {cl_q, el_q};
    if (state_q == S_IDLE) begin
      cen_we    = in_fire && (in_i.mode == kmc_pkg::MODE_LOAD_CEN);
      cen_waddr = {in_i.cluster_index, in_i.element_index};
      cen_wdata = in_i.value;
      cen_raddr = {in_i.cluster_index, in_i.element_index};
    end else if (state_q == S_USH) begin
      cen_we    = 1'b1;
    end

    sum_we    = 1'b0;
    sum_waddr = {bc_q, el_q};
    sum_wdata = sum_new;
    sum_raddr = (state_q == S_SRD) ? {bc_q, el_q} : {cl_q, el_q};
    if (state_q == S_SCLR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_q[kmc_pkg::CA_W-1:0];
      sum_wdata = '0;
    end else if (state_q == S_SWR) begin
      sum_we    = 1'b1;
    end

    asg_we    = 1'b0;
    asg_waddr = pt_q;
    asg_wdata = bc_q;
    asg_raddr = (state_q == S_IDLE) ? in_i.point_index : pt_q;
    if (state_q == S_CLR) begin
      asg_we    = 1'b1;
      asg_waddr = clr_q[kmc_pkg::PT_W-1:0];
      asg_wdata = '0;
    end else if (state_q == S_AWR) begin
      asg_we    = 1'b1;
    end
  end

  kmc_ram #(.WIDTH(VW), .DEPTH(kmc_pkg::MAX_POINTS * kmc_pkg::MAX_DIM)) u_pt_ram (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(pt_wdata),
    .raddr_i(pt_raddr), .rdata_o(pt_rdata)
  );
  kmc_ram #(.WIDTH(VW), .DEPTH(kmc_pkg::MAX_CLUSTERS * kmc_pkg::MAX_DIM)) u_cen_ram (
    .clk_i, .we_i(cen_we), .waddr_i(cen_waddr), .wdata_i(cen_wdata),
    .raddr_i(cen_raddr), .rdata_o(cen_rdata)
  );
  kmc_ram #(.WIDTH(kmc_pkg::SUM_W), .DEPTH(kmc_pkg::MAX_CLUSTERS * kmc_pkg::MAX_DIM)) u_sum_ram (
    .clk_i, .we_i(sum_we), .waddr_i(sum_waddr), .wdata_i(sum_wdata),
    .raddr_i(sum_raddr), .rdata_o(sum_rdata)
  );
  kmc_ram #(.WIDTH(kmc_pkg::CL_W), .DEPTH(kmc_pkg::MAX_POINTS)) u_asg_ram (
    .clk_i, .we_i(asg_we), .waddr_i(asg_waddr), .wdata_i(asg_wdata),
    .raddr_i(asg_raddr), .rdata_o(asg_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      num_points_q   <= kmc_pkg::NP_W'(kmc_pkg::MAX_POINTS);
      vector_dim_q   <= kmc_pkg::ND_W'(kmc_pkg::MAX_DIM);
      num_clusters_q <= kmc_pkg::NK_W'(kmc_pkg::MAX_CLUSTERS);
      iter_limit_q   <= kmc_pkg::IT_W'(20);
      shift_thr_q    <= kmc_pkg::THR_W'(1);
      clr_q          <= '0;
      pt_q           <= '0;
      cl_q           <= '0;
      el_q           <= '0;
      bc_q           <= '0;
      it_q           <= '0;
      dcnt_q         <= '0;
      conv_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      for (int k = 0; k < kmc_pkg::MAX_CLUSTERS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          kmc_pkg::REG_NUM_POINTS:   num_points_q   <= cfg_i.data[kmc_pkg::NP_W-1:0];
          kmc_pkg::REG_VECTOR_DIM:   vector_dim_q   <= cfg_i.data[kmc_pkg::ND_W-1:0];
          kmc_pkg::REG_NUM_CLUSTERS: num_clusters_q <= cfg_i.data[kmc_pkg::NK_W-1:0];
          kmc_pkg::REG_ITER_LIMIT:   iter_limit_q   <= cfg_i.data[kmc_pkg::IT_W-1:0];
          kmc_pkg::REG_SHIFT_THR:    shift_thr_q    <= cfg_i.data;
          default: ;
        endcase
      end

      // The result states load the output register themselves.
      if (out_o.ready && state_q != S_QRES && state_q != S_RES) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q[kmc_pkg::PT_W-1:0] == kmc_pkg::PT_W'(kmc_pkg::MAX_POINTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            pt_q <= in_i.point_index;
            cl_q <= in_i.cluster_index;
            el_q <= in_i.element_index;
            if (in_i.mode == kmc_pkg::MODE_RUN) begin
              it_q    <= '0;
              state_q <= S_ITER;
            end else if (in_i.mode == kmc_pkg::MODE_Q_ASSIGN ||
                         in_i.mode == kmc_pkg::MODE_Q_CEN) begin
              bc_q    <= {kmc_pkg::CL_W{in_i.mode == kmc_pkg::MODE_Q_ASSIGN}};
              state_q <= S_QRES;
            end
          end
        end
        S_QRES: begin
          // bc_q all ones marks an assignment query, zero a centroid query.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ac_q    <= (bc_q[0]) ? asg_rdata : '0;
            out_cv_q    <= (bc_q[0]) ? '0 : $signed(cen_rdata);
            out_it_q    <= '0;
            out_conv_q  <= 1'b0;
            state_q     <= S_IDLE;
          end else if (out_o.ready) begin
            out_valid_q <= 1'b0;
          end
        end
        S_ITER: begin
          for (int k = 0; k < kmc_pkg::MAX_CLUSTERS; k++) begin
            cnt_q[k] <= '0;
          end
          maxs_q  <= '0;
          clr_q   <= '0;
          state_q <= S_SCLR;
        end
        S_SCLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q[kmc_pkg::CA_W-1:0] == {kmc_pkg::CA_W{1'b1}}) begin
            pt_q    <= '0;
            cl_q    <= '0;
            el_q    <= '0;
            acc_q   <= '0;
            state_q <= S_ARD;
          end
        end
        S_ARD: begin
          state_q <= S_AACC;
        end
        S_AACC: begin
          if (el_q == last_el) begin
            if (take_best) begin
              best_q <= acc_sum;
              bc_q   <= cl_q;
            end
            acc_q <= '0;
            el_q  <= '0;
            if (cl_q == last_cl) begin
              state_q <= S_AWR;
            end else begin
              cl_q    <= cl_q + 1'b1;
              state_q <= S_ARD;
            end
          end else begin
            acc_q   <= acc_sum;
            el_q    <= el_q + 1'b1;
            state_q <= S_ARD;
          end
        end
        S_AWR: begin
          cnt_q[bc_q] <= divisor + 1'b1;
          el_q        <= '0;
          state_q     <= S_SRD;
        end
        S_SRD: begin
          state_q <= S_SWR;
        end
        S_SWR: begin
          el_q <= '0;
          cl_q <= '0;
          if (el_q != last_el) begin
            el_q    <= el_q + 1'b1;
            state_q <= S_SRD;
          end else if (pt_q == last_pt) begin
            state_q <= S_UCHK;
          end else begin
            pt_q    <= pt_q + 1'b1;
            acc_q   <= '0;
            state_q <= S_ARD;
          end
        end
        S_UCHK: begin
          el_q  <= '0;
          acc_q <= '0;
          if (divisor != '0) begin
            state_q <= S_URD;
          end else if (cl_q == last_cl) begin
            state_q <= S_ICHK;
          end else begin
            cl_q <= cl_q + 1'b1;
          end
        end
        S_URD: begin
          state_q <= S_ULAT;
        end
        S_ULAT: begin
          neg_q   <= sum_s < 0;
          dq_q    <= (sum_s < 0) ? kmc_pkg::SUM_W'(-sum_s) : sum_rdata;
          rem_q   <= '0;
          old_q   <= $signed(cen_rdata);
          dcnt_q  <= '0;
          state_q <= S_UDIV;
        end
        S_UDIV: begin
          rem_q  <= dge ? dsub[kmc_pkg::NP_W-1:0] : dtrial[kmc_pkg::NP_W-1:0];
          dq_q   <= {dq_q[kmc_pkg::SUM_W-2:0], dge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == kmc_pkg::DC_W'(kmc_pkg::SUM_W - 1)) begin
            state_q <= S_USH;
          end
        end
        S_USH: begin
          if (el_q == last_el) begin
            if (acc_sum > maxs_q) begin
              maxs_q <= acc_sum;
            end
            if (cl_q == last_cl) begin
              state_q <= S_ICHK;
            end else begin
              cl_q    <= cl_q + 1'b1;
              state_q <= S_UCHK;
            end
          end else begin
            acc_q   <= acc_sum;
            el_q    <= el_q + 1'b1;
            state_q <= S_URD;
          end
        end
        S_ICHK: begin
          // The outcome is kept aside so a result still waiting at the output stays intact.
          it_q <= it_next;
          if (maxs_q < kmc_pkg::ACC_W'(shift_thr_q)) begin
            conv_q  <= 1'b1;
            state_q <= S_RES;
          end else if (it_next == lim) begin
            conv_q  <= 1'b0;
            state_q <= S_RES;
          end else begin
            state_q <= S_ITER;
          end
        end
        S_RES: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ac_q    <= '0;
            out_cv_q    <= '0;
            out_it_q    <= it_q;
            out_conv_q  <= conv_q;
            state_q     <= S_IDLE;
          end else if (out_o.ready) begin
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A run item always enters the iteration setup next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.mode == kmc_pkg::MODE_RUN) |=> (state_q == S_ITER))
    else $error("run item did not start an iteration");

  // The winning cluster of a point always lies among the clusters in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AWR) |-> (bc_q <= last_cl))
    else $error("assigned cluster beyond cluster count");

  // A run result always reports at least one iteration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && out_free) |=> (out_valid_q && out_it_q != '0))
    else $error("run result without iterations");

  // Only non-empty clusters are divided.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UDIV) |-> (divisor != '0))
    else $error("division by an empty cluster count");
endmodule
`default_nettype wire
